// ===== hdl/mlr_pkg.sv =====
// Shared types and constants for the midpoint line rasterizer.
// Depends on nothing; every other file of the block imports it.
package mlr_pkg;

    // Pixel coordinate width and the signed decision width.
    localparam int COORD_BITS  = 12;
    localparam int DEC_BITS    = COORD_BITS + 3;

    // Command queue between the setup stage and the stepping stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Command codes carried in the mode field.
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS:0]   t_sdelta;
    typedef logic signed [DEC_BITS-1:0] t_dec;

    // One classified command, as the setup stage hands it to the stepper.
    typedef struct packed {
        logic   mode;
        t_coord x_start;
        t_coord y_start;
        t_coord end_major;
        t_coord delta_major;
        t_coord delta_minor;
        t_dec   decision;
        logic   step_col_neg;
        logic   step_row_neg;
        logic   steep;
        logic   active;
    } t_cmd;

endpackage

// ===== hdl/mlr_if.sv =====
// Valid/ready channel interfaces for the rasterizer's input and output words.
// Depends on mlr_pkg for the coordinate type.
interface mlr_in_if import mlr_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   mode;
    t_coord x_start;
    t_coord y_start;
    t_coord x_end;
    t_coord y_end;

    modport source (output valid, mode, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, mode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface mlr_out_if import mlr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    logic   pixel_valid;
    logic   last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_valid, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last_pixel, output ready);
endinterface

// ===== hdl/mlr_front.sv =====
// Setup stage: accepts input words and classifies each line start.
// Depends on mlr_pkg and mlr_in_if.
module mlr_front import mlr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlr_in_if.sink     i_in,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);

    logic    r_valid;
    t_cmd    r_cmd;
    t_cmd    n_cmd;
    logic    w_accept;
    t_sdelta w_dx;
    t_sdelta w_dy;
    t_coord  w_adx;
    t_coord  w_ady;
    logic    w_steep;
    t_coord  w_dmaj;
    t_coord  w_dmin;

    // The stage frees up whenever its word moves on to the queue.
    assign i_in.ready = !r_valid || i_cmd_ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Signed deltas, their magnitudes and the choice of major axis.
    always_comb begin
        w_dx    = {1'b0, i_in.x_end} - {1'b0, i_in.x_start};
        w_dy    = {1'b0, i_in.y_end} - {1'b0, i_in.y_start};
        w_adx   = w_dx[COORD_BITS] ? COORD_BITS'(-w_dx) : w_dx[COORD_BITS-1:0];
        w_ady   = w_dy[COORD_BITS] ? COORD_BITS'(-w_dy) : w_dy[COORD_BITS-1:0];
        w_steep = w_ady >= w_adx;
        w_dmaj  = w_steep ? w_ady : w_adx;
        w_dmin  = w_steep ? w_adx : w_ady;
    end

    // Build the command word; advance words ignore the setup fields.
    always_comb begin
        n_cmd              = '0;
        n_cmd.mode         = i_in.mode;
        n_cmd.x_start      = i_in.x_start;
        n_cmd.y_start      = i_in.y_start;
        n_cmd.end_major    = w_steep ? i_in.y_end : i_in.x_end;
        n_cmd.delta_major  = w_dmaj;
        n_cmd.delta_minor  = w_dmin;
        n_cmd.decision     = t_dec'({2'b00, w_dmin, 1'b0}) - t_dec'({3'b000, w_dmaj});
        n_cmd.step_col_neg = w_dx[COORD_BITS];
        n_cmd.step_row_neg = w_dy[COORD_BITS];
        n_cmd.steep        = w_steep;
        n_cmd.active       = w_dmaj != '0;
    end

    // Holding register toward the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ===== hdl/mlr_fifo.sv =====
// Short command queue between the setup stage and the stepping stage.
// Depends on mlr_pkg for the command type and the queue depth.
module mlr_fifo import mlr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_push_ready = r_count != QCNT_BITS'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== hdl/mlr_back.sv =====
// Stepping stage: holds the line in progress and emits one output word per command.
// Depends on mlr_pkg and mlr_out_if.
module mlr_back import mlr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    mlr_out_if.source  o_out
);

    // Line state.
    t_coord r_cur_col;
    t_coord r_cur_row;
    t_coord r_end_major;
    t_coord r_delta_major;
    t_coord r_delta_minor;
    t_dec   r_decision;
    logic   r_step_col_neg;
    logic   r_step_row_neg;
    logic   r_steep;
    logic   r_active;

    // Output register.
    logic   r_out_valid;
    t_coord r_pixel_x;
    t_coord r_pixel_y;
    logic   r_pixel_valid;
    logic   r_last_pixel;

    logic   w_take;
    logic   w_minor_step;
    logic   w_col_step;
    logic   w_row_step;
    t_coord w_next_col;
    t_coord w_next_row;
    t_dec   w_next_dec;
    logic   w_last;

    function automatic t_coord step_coord(input t_coord v, input logic neg);
        step_coord = neg ? v - 1'b1 : v + 1'b1;
    endfunction

    // A command is taken whenever the output register is empty or draining.
    assign o_cmd_ready = !r_out_valid || o_out.ready;
    assign w_take      = i_cmd_valid && o_cmd_ready;

    // One midpoint step from the current state.
    always_comb begin
        w_minor_step = !r_decision[DEC_BITS-1];
        w_next_dec   = r_decision + t_dec'({2'b00, r_delta_minor, 1'b0})
                       - (w_minor_step ? t_dec'({2'b00, r_delta_major, 1'b0}) : '0);
        w_col_step   = r_steep ? w_minor_step : 1'b1;
        w_row_step   = r_steep ? 1'b1 : w_minor_step;
        w_next_col   = w_col_step ? step_coord(r_cur_col, r_step_col_neg) : r_cur_col;
        w_next_row   = w_row_step ? step_coord(r_cur_row, r_step_row_neg) : r_cur_row;
        w_last       = (r_steep ? w_next_row : w_next_col) == r_end_major;
    end

    // Line state and output register update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col      <= '0;
            r_cur_row      <= '0;
            r_end_major    <= '0;
            r_delta_major  <= '0;
            r_delta_minor  <= '0;
            r_decision     <= '0;
            r_step_col_neg <= 1'b0;
            r_step_row_neg <= 1'b0;
            r_steep        <= 1'b0;
            r_active       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_pixel_x      <= '0;
            r_pixel_y      <= '0;
            r_pixel_valid  <= 1'b0;
            r_last_pixel   <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_take) begin
                if (i_cmd.mode == MODE_START) begin
                    r_cur_col      <= i_cmd.x_start;
                    r_cur_row      <= i_cmd.y_start;
                    r_end_major    <= i_cmd.end_major;
                    r_delta_major  <= i_cmd.delta_major;
                    r_delta_minor  <= i_cmd.delta_minor;
                    r_decision     <= i_cmd.decision;
                    r_step_col_neg <= i_cmd.step_col_neg;
                    r_step_row_neg <= i_cmd.step_row_neg;
                    r_steep        <= i_cmd.steep;
                    r_active       <= i_cmd.active;
                    r_pixel_x      <= i_cmd.x_start;
                    r_pixel_y      <= i_cmd.y_start;
                    r_pixel_valid  <= 1'b1;
                    r_last_pixel   <= !i_cmd.active;
                end else if (r_active) begin
                    r_cur_col     <= w_next_col;
                    r_cur_row     <= w_next_row;
                    r_decision    <= w_next_dec;
                    r_active      <= !w_last;
                    r_pixel_x     <= w_next_col;
                    r_pixel_y     <= w_next_row;
                    r_pixel_valid <= 1'b1;
                    r_last_pixel  <= w_last;
                end else begin
                    // Advancing with no line in progress gives an empty word.
                    r_pixel_x     <= '0;
                    r_pixel_y     <= '0;
                    r_pixel_valid <= 1'b0;
                    r_last_pixel  <= 1'b0;
                end
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_x     = r_pixel_x;
    assign o_out.pixel_y     = r_pixel_y;
    assign o_out.pixel_valid = r_pixel_valid;
    assign o_out.last_pixel  = r_last_pixel;

endmodule

// ===== hdl/midpoint_line_rasterizer.sv =====
// Top level of the midpoint line rasterizer: setup stage, command queue, stepper.
// Depends on mlr_pkg, mlr_if, mlr_front, mlr_fifo and mlr_back.
//
// Usage:
//   i_in carries one command word per handshake. Mode start loads both
//   endpoints and produces the first pixel; mode advance steps the line
//   by one pixel along its major axis. o_out carries exactly one word per
//   accepted command: the pixel, a valid flag (low when advancing with no
//   line in progress) and a flag on the line's final pixel.
//   An accepted command passes through the setup register, then the
//   command queue, then the output register before its word reaches
//   o_out. Throughput is one word per cycle while o_out.ready stays
//   high; the queue of four commands lets the setup side keep accepting
//   while the output is briefly stalled.
//   When the receiver holds o_out.ready low the output word holds, the
//   queue fills, and i_in.ready falls once the queue and the setup
//   register are both full. Synchronous active-low reset empties the
//   queue, drops any line in progress and clears o_out.valid.
module midpoint_line_rasterizer import mlr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlr_in_if.sink     i_in,
    mlr_out_if.source  o_out
);

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;
    logic w_q_valid;
    logic w_q_ready;
    t_cmd w_q_cmd;

    // Setup stage.
    mlr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    // Command queue.
    mlr_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_cmd_valid),
        .o_push_ready (w_cmd_ready),
        .i_push_cmd   (w_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    // Stepping stage.
    mlr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_out       (o_out)
    );

    // An empty word carries no pixel and no final-pixel flag.
    a_empty_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.pixel_valid |->
            !o_out.last_pixel && o_out.pixel_x == '0 && o_out.pixel_y == '0)
        else $error("empty output word carries pixel data");

    // Input back-pressure only comes from a word held in the setup register.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> w_cmd_valid && !w_cmd_ready)
        else $error("input stalled without a blocked setup word");

    // The stepper refuses a queued command only while the receiver stalls.
    a_back_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid && !w_q_ready |-> o_out.valid && !o_out.ready)
        else $error("stepper stalled without output back-pressure");

endmodule
